// File: hw/rtl/caldc_pkg.sv
`default_nettype none

package caldc_pkg;

    // Year field width and the width of the distance output
    localparam int YEAR_W = 14;
    localparam int DIST_W = 16;

    // Command codes carried in the request
    typedef enum logic [2:0] {
        FN_LOAD  = 3'd0,
        FN_FWD   = 3'd1,
        FN_BACK  = 3'd2,
        FN_ADD   = 3'd3,
        FN_QUERY = 3'd4
    } func_t;

    // Result status codes
    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_BAD_LOAD = 2'd1,
        STS_FAR      = 2'd2
    } status_t;

    // Controller states
    typedef enum logic [1:0] {
        CS_IDLE,
        CS_ADD,
        CS_WALK
    } ctrl_state_t;

    // Selects how the result register is filled
    typedef enum logic [1:0] {
        RK_OK,
        RK_BAD_LOAD,
        RK_FAR,
        RK_DIST
    } res_kind_t;

    // Year first so that a packed compare orders dates
    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic [3:0]        month;
        logic [4:0]        day;
    } date_t;

    typedef struct packed {
        func_t             func;
        logic [4:0]        in_day;
        logic [3:0]        in_month;
        logic [YEAR_W-1:0] in_year;
        logic [15:0]       day_count;
    } in_req_t;

    typedef struct packed {
        logic [4:0]        out_day;
        logic [3:0]        out_month;
        logic [YEAR_W-1:0] out_year;
        logic              is_equal;
        logic              is_greater;
        logic [DIST_W-1:0] distance;
        status_t           status;
    } out_res_t;

    // Controller to datapath
    typedef struct packed {
        logic      exec;       // request accepted this cycle
        logic      add_step;   // advance stored date, count down
        logic      walk_step;  // advance walking date, count up
        logic      res_wr;     // capture result
        res_kind_t res_kind;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_load;
        logic is_add;
        logic is_query;
        logic load_bad;
        logic add_zero;
        logic walk_needed;
        logic cnt_zero;
        logic walk_hit;
        logic walk_limit;
    } dp_status_t;

    // Divisibility by 25 through a reciprocal multiply (exact below 16384)
    function automatic logic div_by_25(input logic [YEAR_W-1:0] y);
        logic [26:0] prod;
        logic [9:0]  q;
        prod = 27'(y) * 27'd5243;
        q    = prod[26:17];
        return (14'(q) * 14'd25) == y;
    endfunction

    // Every 4th year, except every 100th, except every 400th
    function automatic logic leap_year(input logic [YEAR_W-1:0] y);
        logic d25;
        d25 = div_by_25(y);
        return (y[1:0] == 2'd0) && (!d25 || (y[3:0] == 4'd0));
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m,
                                             input logic [YEAR_W-1:0] y);
        logic [4:0] len;
        if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
            len = 5'd30;
        end else if (m == 4'd2) begin
            len = leap_year(y) ? 5'd29 : 5'd28;
        end else begin
            len = 5'd31;
        end
        return len;
    endfunction

    function automatic logic date_valid(input date_t dt);
        logic ok;
        ok = (dt.month >= 4'd1) && (dt.month <= 4'd12) && (dt.day != 5'd0) &&
             (dt.day <= month_len(dt.month, dt.year));
        return ok;
    endfunction

    function automatic date_t next_day(input date_t dt);
        date_t r;
        r = dt;
        if (dt.day >= month_len(dt.month, dt.year)) begin
            r.day = 5'd1;
            if (dt.month >= 4'd12) begin
                r.month = 4'd1;
                r.year  = dt.year + 1'b1;
            end else begin
                r.month = dt.month + 4'd1;
            end
        end else begin
            r.day = dt.day + 5'd1;
        end
        return r;
    endfunction

    function automatic date_t prev_day(input date_t dt);
        date_t r;
        r = dt;
        if (dt.day <= 5'd1) begin
            if (dt.month <= 4'd1) begin
                r.month = 4'd12;
                r.year  = dt.year - 1'b1;
            end else begin
                r.month = dt.month - 4'd1;
            end
            r.day = month_len(r.month, r.year);
        end else begin
            r.day = dt.day - 5'd1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/caldc_datapath.sv
`default_nettype none

module caldc_datapath #(
    parameter int MAX_DISTANCE = 65535
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  caldc_pkg::in_req_t   req,
    input  caldc_pkg::dp_cmd_t   cmd,
    output caldc_pkg::dp_status_t sts,
    output caldc_pkg::out_res_t  res
);

    localparam logic [15:0] LIMIT = (MAX_DISTANCE > 65535) ? 16'hFFFF
                                                            : 16'(MAX_DISTANCE);

    caldc_pkg::date_t    cur_reg, cur_next;
    caldc_pkg::date_t    walk_reg, walk_next;
    logic [15:0]         cnt_reg, cnt_next;
    logic                eq_reg, eq_next;
    logic                gt_reg, gt_next;
    caldc_pkg::out_res_t res_reg, res_next;

    caldc_pkg::date_t given;
    caldc_pkg::date_t step_src;
    caldc_pkg::date_t step_nxt;
    logic             given_ok;
    logic             cmp_eq;
    logic             cmp_gt;
    logic             is_query;

    // Decode the request against the stored date
    always_comb begin
        given.year  = req.in_year;
        given.month = req.in_month;
        given.day   = req.in_day;
        given_ok    = caldc_pkg::date_valid(given);
        cmp_eq      = (cur_reg == given);
        cmp_gt      = (cur_reg > given);
        is_query    = (req.func == caldc_pkg::FN_QUERY);
    end

    // Shared forward step unit: walking date or stored date
    always_comb begin
        step_src = cmd.walk_step ? walk_reg : cur_reg;
        step_nxt = caldc_pkg::next_day(step_src);
    end

    // Report status to the controller
    always_comb begin
        sts.is_load     = (req.func == caldc_pkg::FN_LOAD);
        sts.is_add      = (req.func == caldc_pkg::FN_ADD);
        sts.is_query    = is_query;
        sts.load_bad    = !given_ok;
        sts.add_zero    = (req.day_count == 16'd0);
        sts.walk_needed = given_ok && (cmp_eq || cmp_gt);
        sts.cnt_zero    = (cnt_reg == 16'd0);
        sts.walk_hit    = (walk_reg == cur_reg);
        sts.walk_limit  = (cnt_reg == LIMIT);
    end

    // Update the stored date, walker, counter and flags
    always_comb begin
        cur_next  = cur_reg;
        walk_next = walk_reg;
        cnt_next  = cnt_reg;
        eq_next   = eq_reg;
        gt_next   = gt_reg;
        if (cmd.exec) begin
            case (req.func)
                caldc_pkg::FN_LOAD: begin
                    if (given_ok) begin
                        cur_next = given;
                    end
                end
                caldc_pkg::FN_FWD:  cur_next = step_nxt;
                caldc_pkg::FN_BACK: cur_next = caldc_pkg::prev_day(cur_reg);
                caldc_pkg::FN_ADD:  cnt_next = req.day_count;
                caldc_pkg::FN_QUERY: begin
                    walk_next = given;
                    cnt_next  = 16'd0;
                end
                default: cur_next = cur_reg;
            endcase
            eq_next = is_query && cmp_eq;
            gt_next = is_query && cmp_gt;
        end else if (cmd.add_step) begin
            cur_next = step_nxt;
            cnt_next = cnt_reg - 16'd1;
        end else if (cmd.walk_step) begin
            walk_next = step_nxt;
            cnt_next  = cnt_reg + 16'd1;
        end
    end

    // Build the result from the updated date
    always_comb begin
        res_next = res_reg;
        if (cmd.res_wr) begin
            res_next.out_day    = cur_next.day;
            res_next.out_month  = cur_next.month;
            res_next.out_year   = cur_next.year;
            res_next.is_equal   = cmd.exec ? eq_next : eq_reg;
            res_next.is_greater = cmd.exec ? gt_next : gt_reg;
            res_next.distance   = 16'd0;
            case (cmd.res_kind)
                caldc_pkg::RK_OK:       res_next.status = caldc_pkg::STS_OK;
                caldc_pkg::RK_BAD_LOAD: res_next.status = caldc_pkg::STS_BAD_LOAD;
                caldc_pkg::RK_FAR:      res_next.status = caldc_pkg::STS_FAR;
                caldc_pkg::RK_DIST: begin
                    res_next.status   = caldc_pkg::STS_OK;
                    res_next.distance = cnt_reg;
                end
                default: res_next.status = caldc_pkg::STS_OK;
            endcase
        end
    end

    // Stored date register; reset sets it to 1 January 2000
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg.day   <= 5'd1;
            cur_reg.month <= 4'd1;
            cur_reg.year  <= 14'd2000;
        end else begin
            cur_reg <= cur_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        walk_reg <= walk_next;
        cnt_reg  <= cnt_next;
        eq_reg   <= eq_next;
        gt_reg   <= gt_next;
        res_reg  <= res_next;
    end

    assign res = res_reg;

endmodule

`default_nettype wire

// File: hw/rtl/caldc_ctrl.sv
`default_nettype none

module caldc_ctrl (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  wire                   m_ready,
    input  caldc_pkg::dp_status_t sts,
    output caldc_pkg::dp_cmd_t    cmd
);

    caldc_pkg::ctrl_state_t state_reg, state_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_free;

    assign out_free = !out_valid_reg || m_ready;

    // Next state and datapath commands
    always_comb begin
        state_next   = state_reg;
        cmd.exec      = 1'b0;
        cmd.add_step  = 1'b0;
        cmd.walk_step = 1'b0;
        cmd.res_wr    = 1'b0;
        cmd.res_kind  = caldc_pkg::RK_OK;
        s_ready       = 1'b0;
        case (state_reg)
            caldc_pkg::CS_IDLE: begin
                s_ready = out_free;
                if (s_valid && out_free) begin
                    cmd.exec   = 1'b1;
                    cmd.res_wr = 1'b1;
                    if (sts.is_load && sts.load_bad) begin
                        cmd.res_kind = caldc_pkg::RK_BAD_LOAD;
                    end else if (sts.is_add && !sts.add_zero) begin
                        cmd.res_wr = 1'b0;
                        state_next = caldc_pkg::CS_ADD;
                    end else if (sts.is_query) begin
                        if (sts.walk_needed) begin
                            cmd.res_wr = 1'b0;
                            state_next = caldc_pkg::CS_WALK;
                        end else begin
                            cmd.res_kind = caldc_pkg::RK_FAR;
                        end
                    end
                end
            end
            caldc_pkg::CS_ADD: begin
                // Step until the count runs out, then post the date
                if (!sts.cnt_zero) begin
                    cmd.add_step = 1'b1;
                end else if (out_free) begin
                    cmd.res_wr = 1'b1;
                    state_next = caldc_pkg::CS_IDLE;
                end
            end
            caldc_pkg::CS_WALK: begin
                // Walk from the given date until it meets the stored one or the count reaches the limit
                if (sts.walk_hit) begin
                    if (out_free) begin
                        cmd.res_wr   = 1'b1;
                        cmd.res_kind = caldc_pkg::RK_DIST;
                        state_next   = caldc_pkg::CS_IDLE;
                    end
                end else if (sts.walk_limit) begin
                    if (out_free) begin
                        cmd.res_wr   = 1'b1;
                        cmd.res_kind = caldc_pkg::RK_FAR;
                        state_next   = caldc_pkg::CS_IDLE;
                    end
                end else begin
                    cmd.walk_step = 1'b1;
                end
            end
            default: state_next = caldc_pkg::CS_IDLE;
        endcase
    end

    // Track the output register
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.res_wr) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= caldc_pkg::CS_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

`default_nettype wire

// File: hw/rtl/calendar_date_counter_unit.sv
// Channel   Ports                       Moves
// input     s_valid s_ready s_data      one request: command and given date
// output    m_valid m_ready m_data      one result: stored date, flags, status
//
// Load, step forward, step back, unused codes, a zero Add and a Query with an
// invalid or later given date write their result in the accepting cycle. An
// Add steps the stored date day_count times, one step of the shared next-day
// unit per cycle; a Query walks up from the given date, capped at the distance
// limit. Reset sets the stored date to 1 January 2000. A request is taken only
// while the output register is empty or its result is accepted downstream.
`default_nettype none

module calendar_date_counter_unit #(
    parameter int MAX_DISTANCE = 65535
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  caldc_pkg::in_req_t  s_data,
    output logic                m_valid,
    input  wire                 m_ready,
    output caldc_pkg::out_res_t m_data
);

    caldc_pkg::dp_cmd_t    cmd;
    caldc_pkg::dp_status_t sts;

    caldc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    caldc_datapath #(
        .MAX_DISTANCE (MAX_DISTANCE)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .res     (m_data)
    );

endmodule

`default_nettype wire
